>>> hw/rtl/ln_pkg.sv
`default_nettype none
package ln_pkg;

  localparam int MAX_DIM = 64;
  localparam int IDX_W   = 6;
  localparam int DIM_W   = 7;
  localparam int SMP_W   = 16;
  localparam int EPS_W   = 16;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DAT_W = 16;

  localparam int SUM_W  = 22;   // sum of up to 64 samples
  localparam int MEAN_W = 24;   // Q8.16 mean of Q8.8 samples
  localparam int DIFF_W = 25;
  localparam int MAG_W  = 24;
  localparam int ACC_W  = 40;
  localparam int VAR_W  = 41;
  localparam int PROD_W = 41;
  localparam int DVD_W  = 40;   // divider dividend magnitude
  localparam int DVS_W  = 32;   // divider divisor
  localparam int QUO_W  = 41;   // signed floor quotient
  localparam int ROOT_W = 32;
  localparam int RAD_W  = 64;

  localparam logic KIND_LOAD = 1'b0;
  localparam logic KIND_DATA = 1'b1;

  localparam logic [CFG_IDX_W-1:0] REG_DIM = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_EPS = 2'd1;

  localparam logic [DIM_W-1:0] DIM_RESET = 7'd64;
  localparam logic [EPS_W-1:0] EPS_RESET = 16'd1;

  typedef struct packed {
    logic                    kind;
    logic [IDX_W-1:0]        position;
    logic signed [SMP_W-1:0] sample;
    logic signed [SMP_W-1:0] gain;
    logic signed [SMP_W-1:0] offset;
  } ln_in_t;

  typedef struct packed {
    logic [IDX_W-1:0]        out_position;
    logic signed [SMP_W-1:0] normalized;
    logic                    clipped;
    logic                    last_of_vector;
  } ln_out_t;

  typedef enum logic [1:0] {
    DIV_MEAN,
    DIV_VAR,
    DIV_Y
  } ln_div_sel_t;

  typedef enum logic [4:0] {
    S_IDLE,
    S_SUM_RD,
    S_SUM_ACC,
    S_MEAN_GO,
    S_MEAN_WAIT,
    S_VAR_RD,
    S_VAR_ACC,
    S_VAR_GO,
    S_VAR_WAIT,
    S_SQ_GO,
    S_SQ_WAIT,
    S_OUT_RD,
    S_OUT_MUL,
    S_OUT_GO,
    S_OUT_WAIT,
    S_OUT_PUT
  } ln_state_t;

  typedef struct packed {
    logic        accept;
    logic        idx_clr;
    logic        idx_inc;
    logic        sum_acc;
    logic        var_acc;
    logic        div_start;
    ln_div_sel_t div_sel;
    logic        mean_cap;
    logic        var_cap;
    logic        sqrt_start;
    logic        root_cap;
    logic        prod_cap;
    logic        out_load;
  } ln_cmd_t;

  typedef struct packed {
    logic vec_done;
    logic idx_last;
    logic div_done;
    logic sqrt_done;
    logic out_free;
  } ln_sts_t;

endpackage
`default_nettype wire

>>> hw/rtl/layer_normalization_top.sv
// Layer normalization of vectors of signed Q8.8 samples. A load transaction
// (kind 0) writes gamma and beta for one position. A data transaction
// (kind 1) appends a sample to the vector buffer; the one that completes a
// vector of dim_in_use samples starts the normalization, during which no
// input transaction is taken. The vector is then processed by a shared
// bit-serial divider and a bit-serial square root: the mean pass reads and
// sums every element and then divides, the variance pass reads every element,
// accumulates its squared difference from the mean and then divides, the
// root is taken, and each output element is read, multiplied by gamma,
// divided by the root and offset by beta. Results leave through a registered
// output stage, so the last result of a vector may wait while the next input
// transactions are already taken. The gamma, beta and sample stores come out
// of reset undefined and must be written before use.
// Configuration writes are accepted at any time but must only be made while
// the block is idle.
`default_nettype none
module layer_normalization_top
  import ln_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_valid,
  output logic                       in_ready,
  input  wire ln_in_t                in_data,
  output logic                       out_valid,
  input  wire logic                  out_ready,
  output ln_out_t                    out_data,
  input  wire logic                  cfg_we,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DAT_W-1:0]  cfg_data
);

  // The controller sequences the passes; the datapath holds all storage.
  ln_cmd_t cmd;
  ln_sts_t sts;

  ln_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  ln_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cmd       (cmd),
    .sts       (sts),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule
`default_nettype wire

>>> hw/rtl/ln_div.sv
`default_nettype none
module ln_div
  import ln_pkg::*;
(
  input  wire logic                    clk,
  input  wire logic                    rst_n,
  input  wire logic                    start,
  input  wire logic                    neg,
  input  wire logic [DVD_W-1:0]        dividend,
  input  wire logic [DVS_W-1:0]        divisor,
  output logic                         done,
  output logic signed [QUO_W-1:0]      quotient
);

  // Restoring division on magnitudes, one quotient bit per cycle, then floor.
  logic               busy_r, busy_nxt;
  logic               done_r, done_nxt;
  logic [5:0]         cnt_r, cnt_nxt;
  logic [DVD_W-1:0]   q_r, q_nxt;
  logic [DVS_W-1:0]   rem_r, rem_nxt;
  logic [DVS_W-1:0]   dvs_r, dvs_nxt;
  logic               neg_r, neg_nxt;
  logic [DVS_W:0]     rem_sh;
  logic [QUO_W-1:0]   q_ext;

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    q_nxt    = q_r;
    rem_nxt  = rem_r;
    dvs_nxt  = dvs_r;
    neg_nxt  = neg_r;
    rem_sh   = {rem_r, q_r[DVD_W-1]};
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = 6'(DVD_W - 1);
      q_nxt    = dividend;
      rem_nxt  = '0;
      dvs_nxt  = divisor;
      neg_nxt  = neg;
    end else if (busy_r) begin
      if (rem_sh >= {1'b0, dvs_r}) begin
        rem_nxt = DVS_W'(rem_sh - {1'b0, dvs_r});
        q_nxt   = {q_r[DVD_W-2:0], 1'b1};
      end else begin
        rem_nxt = rem_sh[DVS_W-1:0];
        q_nxt   = {q_r[DVD_W-2:0], 1'b0};
      end
      cnt_nxt = cnt_r - 6'd1;
      if (cnt_r == '0) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
    cnt_r <= cnt_nxt;
    q_r   <= q_nxt;
    rem_r <= rem_nxt;
    dvs_r <= dvs_nxt;
    neg_r <= neg_nxt;
  end

  assign q_ext    = {1'b0, q_r};
  assign done     = done_r;
  assign quotient = neg_r ? $signed(QUO_W'(0) - q_ext - QUO_W'(rem_r != '0))
                          : $signed(q_ext);

endmodule
`default_nettype wire

>>> hw/rtl/ln_sqrt.sv
`default_nettype none
module ln_sqrt
  import ln_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              start,
  input  wire logic [RAD_W-1:0]  radicand,
  output logic                   done,
  output logic [ROOT_W-1:0]      root
);

  // Digit-by-digit square root, two radicand bits per cycle.
  logic               busy_r, busy_nxt;
  logic               done_r, done_nxt;
  logic [4:0]         cnt_r, cnt_nxt;
  logic [RAD_W-1:0]   rad_r, rad_nxt;
  logic [35:0]        rem_r, rem_nxt;
  logic [ROOT_W-1:0]  root_r, root_nxt;
  logic [35:0]        rem_sh, trial;

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    rad_nxt  = rad_r;
    rem_nxt  = rem_r;
    root_nxt = root_r;
    rem_sh   = {rem_r[33:0], rad_r[RAD_W-1:RAD_W-2]};
    trial    = {2'b00, root_r, 2'b01};
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = 5'd31;
      rad_nxt  = radicand;
      rem_nxt  = '0;
      root_nxt = '0;
    end else if (busy_r) begin
      if (rem_sh >= trial) begin
        rem_nxt  = rem_sh - trial;
        root_nxt = {root_r[ROOT_W-2:0], 1'b1};
      end else begin
        rem_nxt  = rem_sh;
        root_nxt = {root_r[ROOT_W-2:0], 1'b0};
      end
      rad_nxt = {rad_r[RAD_W-3:0], 2'b00};
      cnt_nxt = cnt_r - 5'd1;
      if (cnt_r == '0) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
    cnt_r  <= cnt_nxt;
    rad_r  <= rad_nxt;
    rem_r  <= rem_nxt;
    root_r <= root_nxt;
  end

  assign done = done_r;
  assign root = root_r;

endmodule
`default_nettype wire

>>> hw/rtl/ln_ctrl.sv
`default_nettype none
module ln_ctrl
  import ln_pkg::*;
(
  input  wire logic    clk,
  input  wire logic    rst_n,
  input  wire logic    in_valid,
  output logic         in_ready,
  input  wire ln_sts_t sts,
  output ln_cmd_t      cmd
);

  ln_state_t state_r, state_nxt;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE:      if (in_valid && sts.vec_done) state_nxt = S_SUM_RD;
      S_SUM_RD:    state_nxt = S_SUM_ACC;
      S_SUM_ACC:   state_nxt = sts.idx_last ? S_MEAN_GO : S_SUM_RD;
      S_MEAN_GO:   state_nxt = S_MEAN_WAIT;
      S_MEAN_WAIT: if (sts.div_done) state_nxt = S_VAR_RD;
      S_VAR_RD:    state_nxt = S_VAR_ACC;
      S_VAR_ACC:   state_nxt = sts.idx_last ? S_VAR_GO : S_VAR_RD;
      S_VAR_GO:    state_nxt = S_VAR_WAIT;
      S_VAR_WAIT:  if (sts.div_done) state_nxt = S_SQ_GO;
      S_SQ_GO:     state_nxt = S_SQ_WAIT;
      S_SQ_WAIT:   if (sts.sqrt_done) state_nxt = S_OUT_RD;
      S_OUT_RD:    state_nxt = S_OUT_MUL;
      S_OUT_MUL:   state_nxt = S_OUT_GO;
      S_OUT_GO:    state_nxt = S_OUT_WAIT;
      S_OUT_WAIT:  if (sts.div_done) state_nxt = S_OUT_PUT;
      S_OUT_PUT:   if (sts.out_free) state_nxt = sts.idx_last ? S_IDLE : S_OUT_RD;
      default:     state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    cmd      = '0;
    cmd.div_sel = DIV_MEAN;
    in_ready = 1'b0;
    case (state_r)
      S_IDLE: begin
        in_ready   = 1'b1;
        cmd.accept = in_valid;
        cmd.idx_clr = 1'b1;
      end
      S_SUM_ACC: begin
        cmd.sum_acc = 1'b1;
        cmd.idx_inc = !sts.idx_last;
        cmd.idx_clr = sts.idx_last;
      end
      S_MEAN_GO: begin
        cmd.div_start = 1'b1;
        cmd.div_sel   = DIV_MEAN;
      end
      S_MEAN_WAIT: cmd.mean_cap = sts.div_done;
      S_VAR_ACC: begin
        cmd.var_acc = 1'b1;
        cmd.idx_inc = !sts.idx_last;
        cmd.idx_clr = sts.idx_last;
      end
      S_VAR_GO: begin
        cmd.div_start = 1'b1;
        cmd.div_sel   = DIV_VAR;
      end
      S_VAR_WAIT:  cmd.var_cap = sts.div_done;
      S_SQ_GO:     cmd.sqrt_start = 1'b1;
      S_SQ_WAIT:   cmd.root_cap = sts.sqrt_done;
      S_OUT_MUL:   cmd.prod_cap = 1'b1;
      S_OUT_GO: begin
        cmd.div_start = 1'b1;
        cmd.div_sel   = DIV_Y;
      end
      S_OUT_PUT: begin
        cmd.out_load = sts.out_free;
        cmd.idx_inc  = sts.out_free && !sts.idx_last;
      end
      default: cmd.div_sel = DIV_MEAN;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule
`default_nettype wire

>>> hw/rtl/ln_dp.sv
`default_nettype none
module ln_dp
  import ln_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire ln_in_t                in_data,
  input  wire logic                  cfg_we,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DAT_W-1:0]  cfg_data,
  input  wire ln_cmd_t               cmd,
  output ln_sts_t                    sts,
  output logic                       out_valid,
  input  wire logic                  out_ready,
  output ln_out_t                    out_data
);

  logic [DIM_W-1:0] dim_r;
  logic [EPS_W-1:0] eps_r;
  logic [DIM_W-1:0] deff;
  logic [DIM_W-1:0] fill_r;
  logic [DIM_W-1:0] fill_inc;
  logic [IDX_W-1:0] idx_r;

  logic signed [SMP_W-1:0] gain_mem [MAX_DIM];
  logic signed [SMP_W-1:0] off_mem  [MAX_DIM];
  logic signed [SMP_W-1:0] smp_mem  [MAX_DIM];
  logic signed [SMP_W-1:0] gain_rd_r, off_rd_r, smp_rd_r;

  logic signed [SUM_W-1:0]  sum_r;
  logic signed [MEAN_W-1:0] mean_r;
  logic [ACC_W-1:0]         acc_r;
  logic [VAR_W-1:0]         var_r;
  logic [VAR_W-1:0]         var_sum;
  logic [ROOT_W-1:0]        root_r;
  logic signed [PROD_W-1:0] prod_r;

  logic signed [DIFF_W-1:0] diff;
  logic [MAG_W-1:0]         dmag;
  logic [2*MAG_W-1:0]       sq;
  logic [SUM_W-1:0]         sum_mag;
  logic [PROD_W-1:0]        prod_mag;

  logic                     div_neg;
  logic [DVD_W-1:0]         div_dvd;
  logic [DVS_W-1:0]         div_dvs;
  logic                     div_done;
  logic signed [QUO_W-1:0]  quot;
  logic                     sqrt_done;
  logic [ROOT_W-1:0]        root;

  logic signed [QUO_W:0]    y;
  logic signed [SMP_W-1:0]  y_sat;
  logic                     y_clip;

  logic    out_valid_r;
  ln_out_t out_r;

  always_comb begin
    if (dim_r == '0) begin
      deff = DIM_W'(1);
    end else if (dim_r > DIM_W'(MAX_DIM)) begin
      deff = DIM_W'(MAX_DIM);
    end else begin
      deff = dim_r;
    end
  end

  assign fill_inc = fill_r + DIM_W'(1);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dim_r  <= DIM_RESET;
      eps_r  <= EPS_RESET;
      fill_r <= '0;
    end else begin
      if (cfg_we && cfg_index == REG_DIM) begin
        dim_r <= cfg_data[DIM_W-1:0];
      end
      if (cfg_we && cfg_index == REG_EPS) begin
        eps_r <= cfg_data[EPS_W-1:0];
      end
      if (cmd.accept && in_data.kind == KIND_DATA) begin
        fill_r <= (fill_inc >= deff) ? '0 : fill_inc;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept && in_data.kind == KIND_LOAD) begin
      gain_mem[in_data.position] <= in_data.gain;
      off_mem[in_data.position]  <= in_data.offset;
    end
    if (cmd.accept && in_data.kind == KIND_DATA) begin
      smp_mem[fill_r[IDX_W-1:0]] <= in_data.sample;
    end
    gain_rd_r <= gain_mem[idx_r];
    off_rd_r  <= off_mem[idx_r];
    smp_rd_r  <= smp_mem[idx_r];
  end

  always_ff @(posedge clk) begin
    if (cmd.idx_clr) begin
      idx_r <= '0;
    end else if (cmd.idx_inc) begin
      idx_r <= idx_r + IDX_W'(1);
    end
  end

  assign diff = DIFF_W'($signed({smp_rd_r, 8'b0})) - DIFF_W'(mean_r);
  assign dmag = diff[DIFF_W-1] ? MAG_W'(-diff) : diff[MAG_W-1:0];
  assign sq   = dmag * dmag;

  assign var_sum = VAR_W'(quot[ACC_W-1:0]) + VAR_W'(eps_r);

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      sum_r <= '0;
      acc_r <= '0;
    end
    if (cmd.sum_acc) begin
      sum_r <= sum_r + SUM_W'(smp_rd_r);
    end
    if (cmd.var_acc) begin
      acc_r <= acc_r + ACC_W'(sq[2*MAG_W-1:16]);
    end
    if (cmd.mean_cap) begin
      mean_r <= quot[MEAN_W-1:0];
    end
    if (cmd.var_cap) begin
      var_r <= (var_sum == '0) ? VAR_W'(1) : var_sum;
    end
    if (cmd.root_cap) begin
      root_r <= root;
    end
    if (cmd.prod_cap) begin
      prod_r <= PROD_W'(gain_rd_r) * PROD_W'(diff);
    end
  end

  assign sum_mag  = sum_r[SUM_W-1] ? SUM_W'(-sum_r) : SUM_W'(sum_r);
  assign prod_mag = prod_r[PROD_W-1] ? PROD_W'(-prod_r) : PROD_W'(prod_r);

  always_comb begin
    case (cmd.div_sel)
      DIV_MEAN: begin
        div_neg = sum_r[SUM_W-1];
        div_dvd = DVD_W'({sum_mag, 8'b0});
        div_dvs = DVS_W'(deff);
      end
      DIV_VAR: begin
        div_neg = 1'b0;
        div_dvd = acc_r;
        div_dvs = DVS_W'(deff);
      end
      DIV_Y: begin
        div_neg = prod_r[PROD_W-1];
        div_dvd = prod_mag[DVD_W-1:0];
        div_dvs = root_r;
      end
      default: begin
        div_neg = 1'b0;
        div_dvd = '0;
        div_dvs = DVS_W'(1);
      end
    endcase
  end

  ln_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.div_start),
    .neg      (div_neg),
    .dividend (div_dvd),
    .divisor  (div_dvs),
    .done     (div_done),
    .quotient (quot)
  );

  ln_sqrt u_sqrt (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.sqrt_start),
    .radicand (RAD_W'({var_r, 16'b0})),
    .done     (sqrt_done),
    .root     (root)
  );

  assign y = (QUO_W+1)'(quot) + (QUO_W+1)'(off_rd_r);

  always_comb begin
    y_clip = 1'b0;
    y_sat  = y[SMP_W-1:0];
    if (y > (QUO_W+1)'(32767)) begin
      y_sat  = 16'sh7FFF;
      y_clip = 1'b1;
    end else if (y < -(QUO_W+1)'(32768)) begin
      y_sat  = -16'sh8000;
      y_clip = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
    if (cmd.out_load) begin
      out_r.out_position   <= idx_r;
      out_r.normalized     <= y_sat;
      out_r.clipped        <= y_clip;
      out_r.last_of_vector <= sts.idx_last;
    end
  end

  assign sts.vec_done  = in_data.kind == KIND_DATA && fill_inc >= deff;
  assign sts.idx_last  = {1'b0, idx_r} == deff - DIM_W'(1);
  assign sts.div_done  = div_done;
  assign sts.sqrt_done = sqrt_done;
  assign sts.out_free  = !out_valid_r || out_ready;

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule
`default_nettype wire

>>> hw/rtl/ln_checker.sv
`default_nettype none
module ln_checker
  import ln_pkg::*;
(
  input wire logic    clk,
  input wire logic    rst_n,
  input wire logic    in_ready,
  input wire logic    out_valid,
  input wire logic    out_ready,
  input wire ln_out_t out_data
);

  a_reset_quiet: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid after reset");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("stalled result changed");

  a_idle_last: assert property (@(posedge clk) disable iff (!rst_n)
    in_ready && out_valid |-> out_data.last_of_vector)
    else $error("input taken while vector results pending");

  a_last_gap: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready && out_data.last_of_vector |=> !out_valid)
    else $error("result right after last of vector");

endmodule

bind layer_normalization_top ln_checker u_ln_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);
`default_nettype wire
